// ----- rtl/top_k_largest_tracker_assert.svh -----
// Assertion macros for the top-k tracker
`ifndef TOP_K_LARGEST_TRACKER_ASSERT_SVH
`define TOP_K_LARGEST_TRACKER_ASSERT_SVH

// same-cycle implication, reset held off
`define TKL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset held off
`define TKL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tkl_pkg.sv -----
`default_nettype none
package tkl_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned RANK_W = 6;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  typedef struct packed {
    logic                     opcode;
    logic signed [DATA_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] ranked_value;
    logic        [RANK_W-1:0] rank;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    logic ins;
    logic rot;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_REPORT
  } state_e;

endpackage
`default_nettype wire

// ----- rtl/tkl_cell.sv -----
`default_nettype none
module tkl_cell (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire tkl_pkg::cell_ctl_t                 ctl_i,
  input  wire logic signed [tkl_pkg::DATA_W-1:0]  sample_i,
  input  wire logic                               prev_take_i,
  input  wire logic signed [tkl_pkg::DATA_W-1:0]  prev_value_i,
  input  wire logic                               prev_valid_i,
  input  wire logic signed [tkl_pkg::DATA_W-1:0]  next_value_i,
  input  wire logic                               next_valid_i,
  output logic                                    take_o,
  output logic signed [tkl_pkg::DATA_W-1:0]       value_o,
  output logic                                    valid_o
);

  logic signed [tkl_pkg::DATA_W-1:0] value_q, value_d;
  logic                              valid_q, valid_d;

  assign take_o  = !valid_q || (sample_i > value_q);
  assign value_o = value_q;
  assign valid_o = valid_q;

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (ctl_i.ins) begin
      if (prev_take_i) begin
        value_d = prev_value_i;
        valid_d = prev_valid_i;
      end else if (take_o) begin
        value_d = sample_i;
        valid_d = 1'b1;
      end
    end else if (ctl_i.rot) begin
      value_d = next_value_i;
      valid_d = next_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule
`default_nettype wire

// ----- rtl/top_k_largest_tracker.sv -----
// Keeps the TOP_K largest signed samples seen so far, duplicates counted, in a
// sorted chain of comparator cells. Inserts may follow back to back. A report
// rotates the chain once round, one cell per cycle while the output side does
// not stall, so it occupies the block until the whole chain has turned, and
// emits the held values largest first with rank and last.
// A report with nothing held emits nothing but still rotates the whole chain.
`default_nettype none
module top_k_largest_tracker #(
  parameter int unsigned TOP_K = 20
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  wire tkl_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  output tkl_pkg::out_item_t      out_item_o
);

  `include "top_k_largest_tracker_assert.svh"

  localparam int unsigned CNT_W = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(TOP_K - 1);

  tkl_pkg::state_e    state_q, state_d;
  logic [CNT_W-1:0]   step_q, step_d;
  tkl_pkg::cell_ctl_t ctl;
  logic               in_xfer;
  logic               slot_free;

  logic                              take   [TOP_K];
  logic signed [tkl_pkg::DATA_W-1:0] value  [TOP_K];
  logic                              valid  [TOP_K];

  logic               out_valid_q, out_valid_d;
  tkl_pkg::out_item_t out_item_q, out_item_d;
  logic               head_last;

  assign in_xfer   = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;

  for (genvar g = 0; g < TOP_K; g++) begin : g_cell
    localparam int unsigned NXT = (g + 1) % TOP_K;
    localparam int unsigned PRV = (g == 0) ? 0 : g - 1;
    tkl_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .sample_i     (in_item_i.sample),
      .prev_take_i  ((g == 0) ? 1'b0 : take[PRV]),
      .prev_value_i (value[PRV]),
      .prev_valid_i (valid[PRV]),
      .next_value_i (value[NXT]),
      .next_valid_i (valid[NXT]),
      .take_o       (take[g]),
      .value_o      (value[g]),
      .valid_o      (valid[g])
    );
  end

  // last when the next cell is empty or, on the final step, wraps to the head
  assign head_last = (step_q == LAST_STEP) || !valid[(TOP_K > 1) ? 1 : 0];

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      tkl_pkg::ST_IDLE: begin
        step_d = '0;
        if (in_xfer && (in_item_i.opcode == tkl_pkg::OP_REPORT)) begin
          state_d = tkl_pkg::ST_REPORT;
        end
      end
      tkl_pkg::ST_REPORT: begin
        if (ctl.rot) begin
          step_d = step_q + 1'b1;
          if (step_q == LAST_STEP) begin
            state_d = tkl_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = tkl_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    ctl        = '0;
    case (state_q)
      tkl_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        ctl.ins    = in_xfer && (in_item_i.opcode == tkl_pkg::OP_INSERT);
      end
      tkl_pkg::ST_REPORT: begin
        ctl.rot = slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (ctl.rot && valid[0]) begin
      out_valid_d             = 1'b1;
      out_item_d.ranked_value = value[0];
      out_item_d.rank         = tkl_pkg::RANK_W'(step_q);
      out_item_d.last         = head_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tkl_pkg::ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `TKL_ASSERT_IMP(a_rot_slot_free, clk_i, rst_ni, ctl.rot, !out_valid_q || out_ready_i, "rotation over a held transfer")
  `TKL_ASSERT_NXT(a_rot_ends, clk_i, rst_ni, ctl.rot && (step_q == LAST_STEP), state_q == tkl_pkg::ST_IDLE, "report did not end after full rotation")
  `TKL_ASSERT_NXT(a_emit_loads, clk_i, rst_ni, ctl.rot && valid[0], out_valid_o && (out_item_o.rank == tkl_pkg::RANK_W'($past(step_q))), "report result not loaded")

endmodule
`default_nettype wire

// ----- test/top_k_largest_tracker_tb.sv -----
`timescale 1ns / 100ps

module top_k_largest_tracker_tb;

  localparam int unsigned TOP_K       = 20;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  tkl_pkg::in_item_t  in_item;
  logic               out_ready;
  logic               in_ready_o;
  logic               out_valid_o;
  tkl_pkg::out_item_t out_item_o;

  logic signed [tkl_pkg::DATA_W-1:0] held_top[$];
  tkl_pkg::out_item_t                pending_ranked[$];

  bit          tx_idle_en;
  bit          rx_idle_en;
  int unsigned hold_off_left;
  int unsigned n_errors;
  int unsigned n_inserts;
  int unsigned n_turned_away;
  int unsigned n_reports;
  int unsigned n_results;

  top_k_largest_tracker #(
    .TOP_K(TOP_K)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // keep the held values sorted, largest first; equal values go after those held
  function automatic void fold_sample(input logic signed [tkl_pkg::DATA_W-1:0] v);
    int unsigned pos;
    n_inserts++;
    if (held_top.size() == TOP_K) begin
      if (v <= held_top[TOP_K-1]) begin
        n_turned_away++;
        return;
      end
      void'(held_top.pop_back());
    end
    pos = 0;
    while (pos < held_top.size() && held_top[pos] >= v) pos++;
    held_top.insert(pos, v);
  endfunction

  function automatic void queue_report();
    tkl_pkg::out_item_t want;
    n_reports++;
    for (int i = 0; i < held_top.size(); i++) begin
      want.ranked_value = held_top[i];
      want.rank         = tkl_pkg::RANK_W'(i);
      want.last         = (i == held_top.size() - 1);
      pending_ranked.insert(pending_ranked.size(), want);
    end
  endfunction

  task automatic send_item(input logic op,
                           input logic signed [tkl_pkg::DATA_W-1:0] value);
    tkl_pkg::in_item_t item;
    int unsigned       gap;
    item.opcode = op;
    item.sample = value;
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == tkl_pkg::OP_INSERT) fold_sample(value);
    else queue_report();
    gap = tx_idle_en ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // drop valid, then hold until every expected result has been seen
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_ranked.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic signed [tkl_pkg::DATA_W-1:0] fill[12];
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    fill = '{100, -100, 42, 42, -1, 32'sh7FFF_FFFE, 7, -7, 1000, -1000, 3, 64};
    send_item(tkl_pkg::OP_REPORT, 32'sh5A5A_A5A5);
    send_item(tkl_pkg::OP_INSERT, 32'sh7FFF_FFFF);
    send_item(tkl_pkg::OP_INSERT, 32'sh8000_0000);
    send_item(tkl_pkg::OP_INSERT, 0);
    send_item(tkl_pkg::OP_INSERT, -1);
    send_item(tkl_pkg::OP_INSERT, 1);
    send_item(tkl_pkg::OP_INSERT, 5);
    send_item(tkl_pkg::OP_INSERT, 5);
    send_item(tkl_pkg::OP_INSERT, 5);
    foreach (fill[i]) send_item(tkl_pkg::OP_INSERT, fill[i]);
    send_item(tkl_pkg::OP_INSERT, 32'sh8000_0000);
    send_item(tkl_pkg::OP_INSERT, -5);
    send_item(tkl_pkg::OP_INSERT, -1000);
    send_item(tkl_pkg::OP_INSERT, -2000);
    send_item(tkl_pkg::OP_REPORT, 32'shFFFF_FFFF);
  endtask

  task automatic send_random(input int unsigned report_pct);
    logic signed [tkl_pkg::DATA_W-1:0] v;
    if ($urandom_range(99) < report_pct) begin
      send_item(tkl_pkg::OP_REPORT, $urandom);
      return;
    end
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $urandom_range(16) - 8;
      2: v = $urandom_range(1) ? 32'sh7FFF_FFF0 + $urandom_range(15)
                               : 32'sh8000_0000 + $urandom_range(15);
      default: v = (held_top.size() > 0) ? held_top[$] + $urandom_range(2) - 1
                                         : $urandom;
    endcase
    send_item(tkl_pkg::OP_INSERT, v);
  endtask

  task automatic test_random_stream(input int unsigned n_items);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (n_items) send_random(12);
  endtask

  task automatic test_back_to_back(input int unsigned n_items);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (n_items) send_random(20);
  endtask

  // hold the output side while the sender keeps offering, so the input stalls
  task automatic test_output_hold();
    tx_idle_en    = 1'b0;
    rx_idle_en    = 1'b0;
    hold_off_left = 200;
    send_item(tkl_pkg::OP_REPORT, $urandom);
    repeat (20) send_random(15);
    send_item(tkl_pkg::OP_REPORT, $urandom);
  endtask

  task automatic test_drain_pause();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    wait_drained();
    repeat (10) send_random(25);
    send_item(tkl_pkg::OP_REPORT, $urandom);
  endtask

  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_left > 0) begin
        out_ready <= 1'b0;
        hold_off_left--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (rx_idle_en) stall_left = idle_len();
      end
    end
  end

  always @(posedge clk_i) begin : check_result
    tkl_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_ranked.size() == 0) begin
        $display("%0t: unexpected transfer, value %0d rank %0d last %0b", $time,
                 out_item_o.ranked_value, out_item_o.rank, out_item_o.last);
        n_errors++;
      end else begin
        want = pending_ranked.pop_front();
        n_results++;
        if (out_item_o.ranked_value !== want.ranked_value) begin
          $display("%0t: ranked_value expected %0d actual %0d", $time,
                   want.ranked_value, out_item_o.ranked_value);
          n_errors++;
        end
        if (out_item_o.rank !== want.rank) begin
          $display("%0t: rank expected %0d actual %0d", $time, want.rank,
                   out_item_o.rank);
          n_errors++;
        end
        if (out_item_o.last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last,
                   out_item_o.last);
          n_errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned n;
    for (n = 0; n < CYCLE_LIMIT; n++) @(posedge clk_i);
    $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, n,
             pending_ranked.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    in_item       = '0;
    tx_idle_en    = 1'b0;
    rx_idle_en    = 1'b0;
    hold_off_left = 0;
    n_errors      = 0;
    n_inserts     = 0;
    n_turned_away = 0;
    n_reports     = 0;
    n_results     = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_stream(220);
    test_back_to_back(40);
    test_output_hold();
    test_drain_pause();

    wait_drained();
    repeat (2 * TOP_K + 8) @(posedge clk_i);

    $display("Covered %0d inserts (%0d turned away when full) and %0d reports,",
             n_inserts, n_turned_away, n_reports);
    $display("with %0d ranked results checked and %0d field mismatches.", n_results,
             n_errors);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- top_k_largest_tracker.f -----
+incdir+rtl
rtl/tkl_pkg.sv
rtl/tkl_cell.sv
rtl/top_k_largest_tracker.sv
test/top_k_largest_tracker_tb.sv
